[rtl/core/multi_queue_ring_fifo_top_assert.svh]
// Assertion macros for the multi-queue ring FIFO.
`ifndef MULTI_QUEUE_RING_FIFO_TOP_ASSERT_SVH
`define MULTI_QUEUE_RING_FIFO_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// Implication checked in the same cycle.
`define MQRF_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("mqrf check failed");
// Implication checked in the next cycle.
`define MQRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("mqrf check failed");
`else
`define MQRF_ASSERT(lbl, clk, rstn, ante, cons)
`define MQRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[rtl/core/mqrf_pkg.sv]
// Shared constants and types for the multi-queue ring FIFO.
package mqrf_pkg;

  localparam int QUEUE_DEPTH_DEF  = 16;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int QUEUE_COUNT_DEF  = 6;

  localparam int QID_W   = 3;
  localparam int WORD_W  = 32;
  localparam int OCC_W   = 5;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

endpackage

[rtl/core/multi_queue_ring_fifo_top.sv]
// Multi-queue ring FIFO: several circular queues sharing one entry memory.
//
//   channel  | direction | handshake        | fields
//   in_      | input     | in_valid/in_stall | operation, queue_id, payload_in
//   out_     | output    | out_valid/out_stall | status, payload_out, occupancy
//
// One item per cycle while not stalled; each result appears in the cycle after
// its item is accepted; a popped word comes from the registered memory read.
// Read and write counters live in flops next to the memory and update at accept.
// Reset (synchronous, rst_n low) zeroes all counters; the memory is not cleared.
// A stalled result holds the output register and in_stall rises until it is taken.
`include "multi_queue_ring_fifo_top_assert.svh"

module multi_queue_ring_fifo_top
  import mqrf_pkg::*;
#(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
  parameter int QUEUE_COUNT  = QUEUE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [QID_W-1:0]  in_queue_id,
  input  logic [WORD_W-1:0] in_payload_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [WORD_W-1:0] out_payload_out,
  output logic [OCC_W-1:0]  out_occupancy
);

  localparam int CntMod     = 2 * QUEUE_DEPTH;
  localparam int CW         = $clog2(CntMod);
  localparam int SW         = $clog2(QUEUE_DEPTH);
  localparam int EntryCount = QUEUE_COUNT * QUEUE_DEPTH;
  localparam int AW         = (EntryCount > 1) ? $clog2(EntryCount) : 1;
  localparam int QIW        = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

  logic [PAYLOAD_BITS-1:0] store [EntryCount];
  logic [PAYLOAD_BITS-1:0] rd_data_r;

  logic [CW-1:0] wr_cnt_r [QUEUE_COUNT];
  logic [CW-1:0] rd_cnt_r [QUEUE_COUNT];

  logic          out_valid_r, out_valid_nxt;
  status_t       status_r, status_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic          pop_ok_r;

  logic          out_ready;
  logic          acc;
  logic          q_valid;
  logic [QIW-1:0] q_idx;
  logic [CW-1:0] wc, rc, len;
  logic          full, empty;
  op_t           op;
  logic          push_ok, pop_ok;
  logic [SW-1:0] slot;
  logic [AW-1:0] addr;
  logic [PAYLOAD_BITS-1:0] wr_data;

  function automatic logic [SW-1:0] slot_of(input logic [CW-1:0] cnt);
    logic [CW-1:0] s;
    s = (cnt >= CW'(QUEUE_DEPTH)) ? cnt - CW'(QUEUE_DEPTH) : cnt;
    return s[SW-1:0];
  endfunction

  function automatic logic [CW-1:0] cnt_inc(input logic [CW-1:0] cnt);
    return (cnt == CW'(CntMod - 1)) ? '0 : cnt + 1'b1;
  endfunction

  assign out_ready = !out_valid_r || !out_stall;
  assign in_stall  = !out_ready;
  assign acc       = in_valid && out_ready;

  assign op      = op_t'(in_operation);
  assign q_valid = (int'(in_queue_id) < QUEUE_COUNT);
  assign q_idx   = QIW'(in_queue_id);
  assign wc      = q_valid ? wr_cnt_r[q_idx] : '0;
  assign rc      = q_valid ? rd_cnt_r[q_idx] : '0;
  // modular difference; wraps correctly even when CntMod is 2**CW
  assign len     = (wc >= rc) ? wc - rc : wc - rc + CW'(CntMod);
  assign full    = (len >= CW'(QUEUE_DEPTH));
  assign empty   = (len == '0);

  assign push_ok = (op == OP_PUSH) && !full && q_valid;
  assign pop_ok  = (op == OP_POP) && !empty;

  assign slot    = slot_of((op == OP_PUSH) ? wc : rc);
  assign addr    = AW'(int'(q_idx) * QUEUE_DEPTH + int'(slot));
  assign wr_data = PAYLOAD_BITS'({{PAYLOAD_BITS{1'b0}}, in_payload_in});

  always_comb begin
    status_nxt = ST_OK;
    occ_nxt    = len;
    case (op)
      OP_PUSH: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (!q_valid) begin
          status_nxt = ST_INVALID;
        end else begin
          occ_nxt = len + 1'b1;
        end
      end
      OP_POP: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          occ_nxt = len - 1'b1;
        end
      end
      default: status_nxt = ST_INVALID;
    endcase
    out_valid_nxt = out_ready ? in_valid : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        wr_cnt_r[i] <= '0;
        rd_cnt_r[i] <= '0;
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      if (acc && push_ok) wr_cnt_r[q_idx] <= cnt_inc(wc);
      if (acc && pop_ok)  rd_cnt_r[q_idx] <= cnt_inc(rc);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      status_r <= status_nxt;
      occ_r    <= occ_nxt;
      pop_ok_r <= pop_ok;
    end
  end

  // shared entry memory, at most one access per item
  always_ff @(posedge clk) begin
    if (acc && push_ok) store[addr] <= wr_data;
    if (acc && pop_ok)  rd_data_r <= store[addr];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_payload_out = pop_ok_r ? WORD_W'({{WORD_W{1'b0}}, rd_data_r}) : '0;
  assign out_occupancy   = OCC_W'({{OCC_W{1'b0}}, occ_r});

  `MQRF_ASSERT(a_len_bound, clk, rst_n, in_valid && q_valid, len <= CW'(QUEUE_DEPTH))
  `MQRF_ASSERT(a_invalid_zero_occ, clk, rst_n, out_valid_r && status_r == ST_INVALID, occ_r == '0)
  `MQRF_ASSERT(a_full_not_pop, clk, rst_n, out_valid_r && status_r == ST_FULL, !pop_ok_r)
  `MQRF_ASSERT(a_pop_means_ok, clk, rst_n, out_valid_r && pop_ok_r, status_r == ST_OK)
  `MQRF_ASSERT_NEXT(a_pop_latch, clk, rst_n, acc && pop_ok, pop_ok_r && status_r == ST_OK)

endmodule

[bench/tb_multi_queue_ring_fifo_top.sv]
// Self-checking testbench for the multi-queue ring FIFO top level.
`timescale 1ns / 1ps

module tb_multi_queue_ring_fifo_top;
  import mqrf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct {
    status_t           status;
    logic [WORD_W-1:0] word;
    logic [OCC_W-1:0]  occupancy;
  } fifo_response_t;

  class ring_fifo_scoreboard;
    logic [WORD_W-1:0] slot_words[QUEUE_COUNT_DEF][QUEUE_DEPTH_DEF];
    int unsigned       wr_ptr[QUEUE_COUNT_DEF];
    int unsigned       rd_ptr[QUEUE_COUNT_DEF];
    fifo_response_t    awaited_responses[$];
    logic [WORD_W-1:0] keep_mask;
    int                errors;

    function new();
      keep_mask = (PAYLOAD_BITS_DEF >= WORD_W) ? '1 :
                  WORD_W'((64'd1 << PAYLOAD_BITS_DEF) - 64'd1);
      errors = 0;
      foreach (wr_ptr[q]) begin
        wr_ptr[q] = 0;
        rd_ptr[q] = 0;
      end
    endfunction

    function int unsigned fill_level(int unsigned q);
      return (wr_ptr[q] + 2 * QUEUE_DEPTH_DEF - rd_ptr[q]) % (2 * QUEUE_DEPTH_DEF);
    endfunction

    // Advance the model by one accepted item and queue the response it must give.
    function void predict_access(op_t op, logic [QID_W-1:0] qid, logic [WORD_W-1:0] data);
      fifo_response_t rsp;
      bit             known;
      int unsigned    len;
      int unsigned    q;
      q = 32'(qid);
      known = (q < QUEUE_COUNT_DEF);
      len = known ? fill_level(q) : 0;
      rsp.word = '0;
      if (op == OP_PUSH) begin
        if (len > QUEUE_DEPTH_DEF - 1) begin
          rsp.status = ST_FULL;
        end else if (!known) begin
          rsp.status = ST_INVALID;
        end else begin
          slot_words[q][wr_ptr[q] % QUEUE_DEPTH_DEF] = data & keep_mask;
          wr_ptr[q] = (wr_ptr[q] + 1) % (2 * QUEUE_DEPTH_DEF);
          rsp.status = ST_OK;
        end
      end else begin
        // unknown queue numbers read as empty
        if (len == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.word = slot_words[q][rd_ptr[q] % QUEUE_DEPTH_DEF];
          rd_ptr[q] = (rd_ptr[q] + 1) % (2 * QUEUE_DEPTH_DEF);
          rsp.status = ST_OK;
        end
      end
      rsp.occupancy = OCC_W'(known ? fill_level(q) : 0);
      awaited_responses.push_back(rsp);
    endfunction

    function void check_response(logic [1:0] status, logic [WORD_W-1:0] word,
                                 logic [OCC_W-1:0] occupancy);
      fifo_response_t exp_rsp;
      if (awaited_responses.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d word %h occ %0d",
                 $time, status, word, occupancy);
        errors++;
        return;
      end
      exp_rsp = awaited_responses.pop_front();
      if (status !== exp_rsp.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, exp_rsp.status, status);
        errors++;
      end
      if (word !== exp_rsp.word) begin
        $display("%0t: payload_out mismatch, expected %h actual %h",
                 $time, exp_rsp.word, word);
        errors++;
      end
      if (occupancy !== exp_rsp.occupancy) begin
        $display("%0t: occupancy mismatch, expected %0d actual %0d",
                 $time, exp_rsp.occupancy, occupancy);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return awaited_responses.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_operation;
  logic [QID_W-1:0]  in_queue_id;
  logic [WORD_W-1:0] in_payload_in;
  logic              out_valid;
  logic              out_stall;
  logic [1:0]        out_status;
  logic [WORD_W-1:0] out_payload_out;
  logic [OCC_W-1:0]  out_occupancy;

  ring_fifo_scoreboard sb = new();
  int                  sender_idle_pct = 0;
  int                  receiver_stall_pct = 0;
  int                  cycle_count = 0;

  multi_queue_ring_fifo_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_queue_id     (in_queue_id),
    .in_payload_in   (in_payload_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_payload_out (out_payload_out),
    .out_occupancy   (out_occupancy)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL multi_queue_ring_fifo_top");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Results first: a result seen at this edge never belongs to the item taken now.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_response(out_status, out_payload_out, out_occupancy);
      if (in_valid && !in_stall)
        sb.predict_access(op_t'(in_operation), in_queue_id, in_payload_in);
    end
  end

  task automatic issue_command(op_t op, logic [QID_W-1:0] qid, logic [WORD_W-1:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_operation  <= op;
    in_queue_id   <= qid;
    in_payload_in <= data;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic run_random_bursts(int bursts);
    int          focus;
    int          push_bias;
    logic [2:0]  qid;
    op_t         op;
    for (int b = 0; b < bursts; b++) begin
      // each burst leans on one queue with a random push/pop mix so queues fill and drain
      focus = $urandom_range(QUEUE_COUNT_DEF - 1);
      push_bias = $urandom_range(90, 10);
      for (int i = 0; i < 20; i++) begin
        if ($urandom_range(99) < 10)
          qid = 3'($urandom_range(7, QUEUE_COUNT_DEF));
        else if ($urandom_range(99) < 70)
          qid = 3'(focus);
        else
          qid = 3'($urandom_range(QUEUE_COUNT_DEF - 1));
        op = ($urandom_range(99) < push_bias) ? OP_PUSH : OP_POP;
        issue_command(op, qid, $urandom);
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_operation  = OP_PUSH;
    in_queue_id   = '0;
    in_payload_in = '0;
    out_stall     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: invalid queues, empty pop, fill one queue past full, drain a little
    issue_command(OP_PUSH, 3'd6, 32'hFFFF_FFFF);
    issue_command(OP_PUSH, 3'd7, 32'h0000_0000);
    issue_command(OP_POP,  3'd7, 32'hFFFF_FFFF);
    issue_command(OP_POP,  3'd0, 32'h0000_0000);
    issue_command(OP_PUSH, 3'd1, 32'h0000_0000);
    issue_command(OP_PUSH, 3'd1, 32'hFFFF_FFFF);
    for (int i = 0; i < QUEUE_DEPTH_DEF - 2; i++)
      issue_command(OP_PUSH, 3'd1, $urandom);
    issue_command(OP_PUSH, 3'd1, 32'hA5A5_5A5A);
    issue_command(OP_POP,  3'd1, 32'h0000_0000);
    issue_command(OP_POP,  3'd1, 32'h0000_0000);
    issue_command(OP_PUSH, 3'd5, 32'h8000_0001);
    issue_command(OP_POP,  3'd5, 32'h0000_0000);

    run_random_bursts(9);
    sender_idle_pct = 53;
    receiver_stall_pct = 0;
    run_random_bursts(9);
    sender_idle_pct = 0;
    receiver_stall_pct = 53;
    run_random_bursts(9);
    sender_idle_pct = 25;
    receiver_stall_pct = 25;
    run_random_bursts(9);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("PASS multi_queue_ring_fifo_top");
    else
      $display("FAIL multi_queue_ring_fifo_top");
    $finish;
  end

endmodule
